>>> hdl/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg
// shared types and constants of the cluster chain manager
// ----------------------------------------------------------------------------
package fccm_pkg;

  localparam int TABLE_ENTRIES     = 8192;
  localparam int FIRST_ALLOCATABLE = 3;
  localparam int IDX_W             = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W           = 16;

  localparam logic [ENTRY_W-1:0] FULL_MARK        = 16'hFFFF;
  localparam logic [ENTRY_W-1:0] END_MARKER_RESET = 16'd65528;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_EXTEND = 3'd1,
    OP_FREE   = 3'd2,
    OP_SEEK   = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_ERR  = 2'd2
  } status_e;

  // one write port and one read port of the table
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  // true when a cluster number names an entry of the table
  function automatic logic in_range(input logic [ENTRY_W-1:0] v);
    return {1'b0, v} < (ENTRY_W+1)'(TABLE_ENTRIES);
  endfunction

endpackage

>>> hdl/fccm_ram.sv
// ----------------------------------------------------------------------------
// fccm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fccm_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/fccm_seq.sv
// ----------------------------------------------------------------------------
// fccm_seq
// request sequencer: free-entry scan, chain walks and single-entry access
// ----------------------------------------------------------------------------
module fccm_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [2:0]                         op_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]       cluster_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]       hop_count_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]       entry_value_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]       end_marker_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]       rdata_i,
  output fccm_pkg::mem_req_t                 mem_o,
  output logic                               busy_o,
  output logic                               result_valid_o,
  output logic [1:0]                         status_o,
  output logic [fccm_pkg::ENTRY_W-1:0]       result_cluster_o
);
  import fccm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LINK,
    S_FREE,
    S_SEEK,
    S_READ
  } state_e;

  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(FIRST_ALLOCATABLE);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);

  state_e             state_q, state_d;
  logic               ext_q, ext_d;
  logic [ENTRY_W-1:0] clu_q, clu_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [ENTRY_W-1:0] hops_q, hops_d;
  logic               first_q, first_d;
  logic               byp_q, byp_d;
  logic               valid_q, valid_d;
  logic [1:0]         status_q, status_d;
  logic [ENTRY_W-1:0] res_q, res_d;

  logic [ENTRY_W-1:0] dat;
  logic [ENTRY_W-1:0] sk_cur, sk_hops;
  logic               sk_stop, sk_oor;
  logic               fr_stop;

  // a read issued at the address zeroed in the same cycle sees zero
  assign dat = byp_q ? '0 : rdata_i;

  // shared seek step: start of the walk in idle, fetched link afterwards
  assign sk_cur  = (state_q == S_IDLE) ? cluster_i   : dat;
  assign sk_hops = (state_q == S_IDLE) ? hop_count_i : hops_q;
  assign sk_stop = (sk_hops == '0) || (sk_cur >= end_marker_i);
  assign sk_oor  = !in_range(sk_cur);

  assign fr_stop = (first_q && (ENTRY_W'(idx_q) >= end_marker_i)) || (dat >= end_marker_i);

  always_comb begin
    state_d  = state_q;
    ext_d    = ext_q;
    clu_d    = clu_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    hops_d   = hops_q;
    first_d  = first_q;
    byp_d    = 1'b0;
    valid_d  = 1'b0;
    status_d = status_q;
    res_d    = res_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = idx_q;
    mem_o.wdata = '0;
    mem_o.raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          valid_d  = 1'b1;
          status_d = STAT_ERR;
          res_d    = '0;
          case (op_i)
            OP_ALLOC, OP_EXTEND: begin
              if (op_i == OP_ALLOC || in_range(cluster_i)) begin
                valid_d     = 1'b0;
                mem_o.raddr = IDX_FIRST;
                idx_d       = IDX_FIRST;
                ext_d       = (op_i == OP_EXTEND);
                clu_d       = cluster_i;
                state_d     = S_SCAN;
              end
            end
            OP_FREE: begin
              if (in_range(cluster_i)) begin
                valid_d     = 1'b0;
                mem_o.raddr = cluster_i[IDX_W-1:0];
                idx_d       = cluster_i[IDX_W-1:0];
                first_d     = 1'b1;
                cnt_d       = '0;
                state_d     = S_FREE;
              end
            end
            OP_SEEK: begin
              if (sk_stop) begin
                status_d = (sk_hops != '0) ? STAT_ERR : STAT_OK;
                res_d    = sk_cur;
              end else if (sk_oor) begin
                res_d = sk_cur;
              end else begin
                valid_d     = 1'b0;
                mem_o.raddr = sk_cur[IDX_W-1:0];
                hops_d      = sk_hops - 1'b1;
                state_d     = S_SEEK;
              end
            end
            OP_READ: begin
              if (in_range(cluster_i)) begin
                valid_d     = 1'b0;
                mem_o.raddr = cluster_i[IDX_W-1:0];
                state_d     = S_READ;
              end
            end
            OP_WRITE: begin
              if (in_range(cluster_i)) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = cluster_i[IDX_W-1:0];
                mem_o.wdata = entry_value_i;
                status_d    = STAT_OK;
              end
            end
            default: begin
              status_d = STAT_ERR;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rdata_i == '0) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = FULL_MARK;
          res_d       = ENTRY_W'(idx_q);
          if (ext_q) begin
            state_d = S_LINK;
          end else begin
            valid_d  = 1'b1;
            status_d = STAT_OK;
            state_d  = S_IDLE;
          end
        end else if (idx_q == IDX_LAST) begin
          valid_d  = 1'b1;
          status_d = STAT_FULL;
          res_d    = '0;
          state_d  = S_IDLE;
        end else begin
          mem_o.raddr = idx_q + 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end

      S_LINK: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clu_q[IDX_W-1:0];
        mem_o.wdata = res_q;
        valid_d     = 1'b1;
        status_d    = STAT_OK;
        state_d     = S_IDLE;
      end

      S_FREE: begin
        mem_o.we = 1'b1;
        if (fr_stop) begin
          valid_d  = 1'b1;
          status_d = STAT_OK;
          res_d    = '0;
          state_d  = S_IDLE;
        end else if (cnt_q == IDX_LAST || !in_range(dat)) begin
          valid_d  = 1'b1;
          status_d = STAT_ERR;
          res_d    = '0;
          state_d  = S_IDLE;
        end else begin
          mem_o.raddr = dat[IDX_W-1:0];
          idx_d       = dat[IDX_W-1:0];
          byp_d       = (dat[IDX_W-1:0] == idx_q);
          first_d     = 1'b0;
          cnt_d       = cnt_q + 1'b1;
        end
      end

      S_SEEK: begin
        if (sk_stop) begin
          valid_d  = 1'b1;
          status_d = (sk_hops != '0) ? STAT_ERR : STAT_OK;
          res_d    = sk_cur;
          state_d  = S_IDLE;
        end else if (sk_oor) begin
          valid_d  = 1'b1;
          status_d = STAT_ERR;
          res_d    = sk_cur;
          state_d  = S_IDLE;
        end else begin
          mem_o.raddr = sk_cur[IDX_W-1:0];
          hops_d      = sk_hops - 1'b1;
        end
      end

      S_READ: begin
        valid_d  = 1'b1;
        status_d = STAT_OK;
        res_d    = dat;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= 1'b0;
      byp_q    <= 1'b0;
      status_q <= STAT_OK;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      byp_q    <= byp_d;
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ext_q   <= ext_d;
    clu_q   <= clu_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    hops_q  <= hops_d;
    first_q <= first_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign result_cluster_o = res_q;

  // the strobe ends every request, and only a request
  a_busy_ends_with_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("busy dropped without a result word");

  a_word_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result word without a request");

  a_scan_marks_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_o.we) |-> (mem_o.wdata == FULL_MARK && rdata_i == '0))
    else $error("scan wrote something other than the end mark");

  a_free_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE) |-> (mem_o.we && mem_o.wdata == '0 && mem_o.waddr == idx_q))
    else $error("chain free did not clear the current entry");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == STAT_OK || status_o == STAT_FULL || status_o == STAT_ERR))
    else $error("unknown status code");

endmodule

>>> hdl/fat_cluster_chain_manager_top.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager_top
// fat16 cluster table with allocate, extend, free, seek, read and write
// ----------------------------------------------------------------------------
// usage
//   request: drive op_i, cluster_i, hop_count_i, entry_value_i with start high;
//   the request is taken at a rising edge where start is high and busy is low.
//   busy stays high until the request is done, one request at a time.
//   result: status_o and result_cluster_o hold a word for exactly one cycle,
//   marked by result_valid_o; the receiver cannot stall it, so it must sample.
//   config: cfg_data_i is written to end_marker when cfg_valid_i is high
//   (cfg_ready_o is always high); write it only while the block is idle.
// steps, from the accepting edge to the strobe
//   write entry or any rejected request: the strobe follows in the next cycle
//   read entry: the read is issued at acceptance, S_READ takes the word, the strobe is registered
//   allocate: S_SCAN checks entries from index 3 (up to 8189) for a free one
//   extend: as allocate, then the link write in S_LINK once a free entry is found
//   free chain: S_FREE clears the entries of the chain (at most 8192)
//   seek: S_SEEK fetches at most h links, h the hop count; the ram read port sets one
//   memory access per cycle for scans and walks
// reset: end_marker returns to 65528 and the sequencer goes idle; the table
//   is not cleared and must be loaded by write entry requests
module fat_cluster_chain_manager_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    op_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]  cluster_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]  hop_count_i,
  input  logic [fccm_pkg::ENTRY_W-1:0]  entry_value_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [fccm_pkg::ENTRY_W-1:0]  result_cluster_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fccm_pkg::ENTRY_W-1:0]  cfg_data_i
);
  import fccm_pkg::*;

  logic [ENTRY_W-1:0] end_marker_q;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;

  // config register: always ready; the user must write it only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q <= END_MARKER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      end_marker_q <= cfg_data_i;
    end
  end

  // request sequencer, owns the result word register
  fccm_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .op_i             (op_i),
    .cluster_i        (cluster_i),
    .hop_count_i      (hop_count_i),
    .entry_value_i    (entry_value_i),
    .end_marker_i     (end_marker_q),
    .rdata_i          (rdata),
    .mem_o            (mem_req),
    .busy_o           (busy),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .result_cluster_o (result_cluster_o)
  );

  // cluster table storage
  fccm_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule
